// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the first-fit heap allocator modules.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int MAX_PAGES   = 16;
   localparam int PAGE_SHIFT  = 12;
   localparam int GRAN_SHIFT  = 4;
   localparam int HDR_BYTES   = 32;
   localparam int IDX_W       = 12;
   localparam int LINK_W      = IDX_W + 1;
   localparam int LEN_W       = 17;
   localparam int SIZE_W      = 18;
   localparam int OFF_W       = 16;
   localparam int PAGES_W     = 5;

   // Header size in granules, used to find the split-off block's index.
   localparam int HDR_GRANS   = HDR_BYTES >> GRAN_SHIFT;
   localparam logic [LINK_W-1:0] NO_BLOCK = LINK_W'(1 << IDX_W);

   typedef enum logic [1:0] {
      CMD_INIT  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ZERO  = 2'd1,
      ST_NOFIT = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_ACHK,
      S_AOLD,
      S_ANB,
      S_ACUR,
      S_FCHK,
      S_MSTART,
      S_MNX,
      S_MNN,
      S_MEND,
      S_PCHK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [LINK_W-1:0] nxt;
      logic [LINK_W-1:0] prv;
      logic              free;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

endpackage

// ===== rtl/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffha_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer that walks the block list in the header memory and performs
// init, allocate (with split) and free (with coalescing) one item at a time.
// ----------------------------------------------------------------------------
module ffha_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ffha_pkg::PAGES_W-1:0]  pages,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [16:0]                   req_size,
   input  logic [15:0]                   req_payload_offset,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [15:0]                   rsp_result_offset,
   output logic [1:0]                    rsp_status,
   output ffha_pkg::mem_req_type         mem,
   input  ffha_pkg::entry_type           rdata
);
   import ffha_pkg::*;

   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [IDX_W-1:0]    tgt_ff, tgt_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [LINK_W-1:0]   steps_ff, steps_in;
   entry_type           cur_e_ff, cur_e_in;
   logic [LINK_W-1:0]   old_ff, old_in;
   logic [IDX_W-1:0]    nb_ff, nb_in;
   logic [IDX_W-1:0]    nn_ff, nn_in;
   logic                split_ff, split_in;
   logic                phase_ff, phase_in;
   logic [OFF_W-1:0]    res_off_ff, res_off_in;
   status_type          res_st_ff, res_st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]    rsp_off_ff, rsp_off_in;
   status_type          rsp_st_ff, rsp_st_in;

   logic                accept;
   logic                rsp_load;
   cmd_type             cmd;
   logic [SIZE_W-1:0]   size_rnd;
   logic                bad_off;
   logic [14:0]         nb_full;
   logic                fit;
   logic                split_ok;
   logic                walk_end;
   logic [LEN_W-1:0]    init_len;

   assign cmd      = cmd_type'(req_cmd);
   assign accept   = req_valid && (state_ff == S_IDLE);
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign size_rnd = ({1'b0, req_size} + SIZE_W'((1 << GRAN_SHIFT) - 1))
                     & ~SIZE_W'((1 << GRAN_SHIFT) - 1);
   assign bad_off  = (req_payload_offset < OFF_W'(HDR_BYTES))
                     || (req_payload_offset[GRAN_SHIFT-1:0] != '0);
   assign init_len = LEN_W'({pages, PAGE_SHIFT'(0)}) - LEN_W'(HDR_BYTES);

   // Split point and fit test for the header just read.
   assign nb_full  = {3'b0, cur_ff} + 15'(size_ff[SIZE_W-1:GRAN_SHIFT]) + 15'(HDR_GRANS);
   assign fit      = rdata.free && ({1'b0, rdata.len} >= size_ff);
   assign split_ok = ({1'b0, rdata.len} > size_ff)
                     && ({2'b0, rdata.len} >= ({1'b0, size_ff}
                         + 19'(HDR_BYTES + (1 << GRAN_SHIFT))))
                     && (nb_full[14:IDX_W] == '0);
   assign walk_end = (steps_ff == LINK_W'((1 << IDX_W) - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff    <= size_in;
      tgt_ff     <= tgt_in;
      cur_ff     <= cur_in;
      steps_ff   <= steps_in;
      cur_e_ff   <= cur_e_in;
      old_ff     <= old_in;
      nb_ff      <= nb_in;
      nn_ff      <= nn_in;
      split_ff   <= split_in;
      phase_ff   <= phase_in;
      res_off_ff <= res_off_in;
      res_st_ff  <= res_st_in;
      rsp_off_ff <= rsp_off_in;
      rsp_st_ff  <= rsp_st_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_INIT:  state_in = S_INIT;
                  CMD_ALLOC: state_in = (size_rnd == '0) ? S_DONE : S_ACHK;
                  CMD_FREE:  state_in = bad_off ? S_DONE : S_FCHK;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_INIT: state_in = S_DONE;
         S_ACHK: begin
            if (fit) begin
               if (split_ok && !rdata.nxt[IDX_W]) begin
                  state_in = S_AOLD;
               end else if (split_ok) begin
                  state_in = S_ANB;
               end else begin
                  state_in = S_ACUR;
               end
            end else if (rdata.nxt[IDX_W] || walk_end) begin
               state_in = S_DONE;
            end
         end
         S_AOLD: state_in = S_ANB;
         S_ANB:  state_in = S_ACUR;
         S_ACUR: state_in = S_DONE;
         S_FCHK: begin
            if (cur_ff == tgt_ff) begin
               state_in = rdata.free ? S_DONE : S_MSTART;
            end else if (rdata.nxt[IDX_W] || (steps_ff == NO_BLOCK)) begin
               state_in = S_DONE;
            end
         end
         S_MSTART: state_in = cur_e_ff.nxt[IDX_W] ? S_MEND : S_MNX;
         S_MNX: begin
            if (!rdata.free || rdata.nxt[IDX_W]) begin
               state_in = S_MEND;
            end else begin
               state_in = S_MNN;
            end
         end
         S_MNN: state_in = S_MEND;
         S_MEND: begin
            if (!phase_ff && !cur_e_ff.prv[IDX_W]) begin
               state_in = S_PCHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PCHK: state_in = rdata.free ? S_MSTART : S_DONE;
         S_DONE: state_in = rsp_load ? S_IDLE : S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   // Memory requests and datapath registers.
   always_comb begin
      mem          = '0;
      size_in      = size_ff;
      tgt_in       = tgt_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      cur_e_in     = cur_e_ff;
      old_in       = old_ff;
      nb_in        = nb_ff;
      nn_in        = nn_ff;
      split_in     = split_ff;
      phase_in     = phase_ff;
      res_off_in   = res_off_ff;
      res_st_in    = res_st_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               size_in    = size_rnd;
               tgt_in     = IDX_W'((req_payload_offset - OFF_W'(HDR_BYTES)) >> GRAN_SHIFT);
               cur_in     = '0;
               steps_in   = '0;
               phase_in   = 1'b0;
               res_off_in = '0;
               res_st_in  = ST_OK;
               if (cmd == CMD_ALLOC && size_rnd == '0) begin
                  res_st_in = ST_ZERO;
               end
               mem.re     = 1'b1;
               mem.raddr  = '0;
            end
         end
         S_INIT: begin
            mem.we         = 1'b1;
            mem.waddr      = '0;
            mem.wdata.len  = init_len;
            mem.wdata.nxt  = NO_BLOCK;
            mem.wdata.prv  = NO_BLOCK;
            mem.wdata.free = 1'b1;
         end
         S_ACHK: begin
            cur_e_in = rdata;
            if (fit) begin
               split_in   = split_ok;
               nb_in      = nb_full[IDX_W-1:0];
               old_in     = rdata.nxt[IDX_W] ? NO_BLOCK : rdata.nxt;
               res_off_in = OFF_W'({cur_ff, GRAN_SHIFT'(0)}) + OFF_W'(HDR_BYTES);
               if (split_ok && !rdata.nxt[IDX_W]) begin
                  mem.re    = 1'b1;
                  mem.raddr = rdata.nxt[IDX_W-1:0];
               end
            end else if (rdata.nxt[IDX_W] || walk_end) begin
               res_st_in = ST_NOFIT;
            end else begin
               steps_in  = steps_ff + LINK_W'(1);
               cur_in    = rdata.nxt[IDX_W-1:0];
               mem.re    = 1'b1;
               mem.raddr = rdata.nxt[IDX_W-1:0];
            end
         end
         S_AOLD: begin
            // Successor now points back at the split-off remainder.
            mem.we        = 1'b1;
            mem.waddr     = old_ff[IDX_W-1:0];
            mem.wdata     = rdata;
            mem.wdata.prv = {1'b0, nb_ff};
         end
         S_ANB: begin
            mem.we         = 1'b1;
            mem.waddr      = nb_ff;
            mem.wdata.len  = cur_e_ff.len - LEN_W'(size_ff) - LEN_W'(HDR_BYTES);
            mem.wdata.nxt  = old_ff;
            mem.wdata.prv  = {1'b0, cur_ff};
            mem.wdata.free = cur_e_ff.free;
         end
         S_ACUR: begin
            mem.we         = 1'b1;
            mem.waddr      = cur_ff;
            mem.wdata      = cur_e_ff;
            mem.wdata.free = 1'b0;
            if (split_ff) begin
               mem.wdata.len = LEN_W'(size_ff);
               mem.wdata.nxt = {1'b0, nb_ff};
            end
         end
         S_FCHK: begin
            if (cur_ff == tgt_ff) begin
               cur_e_in      = rdata;
               cur_e_in.free = 1'b1;
            end else if (!rdata.nxt[IDX_W] && (steps_ff != NO_BLOCK)) begin
               steps_in  = steps_ff + LINK_W'(1);
               cur_in    = rdata.nxt[IDX_W-1:0];
               mem.re    = 1'b1;
               mem.raddr = rdata.nxt[IDX_W-1:0];
            end
         end
         S_MSTART: begin
            if (!cur_e_ff.nxt[IDX_W]) begin
               mem.re    = 1'b1;
               mem.raddr = cur_e_ff.nxt[IDX_W-1:0];
            end
         end
         S_MNX: begin
            // Absorb a free successor into the base block.
            if (rdata.free) begin
               cur_e_in.len = cur_e_ff.len + rdata.len + LEN_W'(HDR_BYTES);
               cur_e_in.nxt = rdata.nxt[IDX_W] ? NO_BLOCK : rdata.nxt;
               nn_in        = rdata.nxt[IDX_W-1:0];
               if (!rdata.nxt[IDX_W]) begin
                  mem.re    = 1'b1;
                  mem.raddr = rdata.nxt[IDX_W-1:0];
               end
            end
         end
         S_MNN: begin
            mem.we        = 1'b1;
            mem.waddr     = nn_ff;
            mem.wdata     = rdata;
            mem.wdata.prv = {1'b0, cur_ff};
         end
         S_MEND: begin
            mem.we    = 1'b1;
            mem.waddr = cur_ff;
            mem.wdata = cur_e_ff;
            if (!phase_ff && !cur_e_ff.prv[IDX_W]) begin
               mem.re    = 1'b1;
               mem.raddr = cur_e_ff.prv[IDX_W-1:0];
            end
         end
         S_PCHK: begin
            if (rdata.free) begin
               cur_in   = cur_e_ff.prv[IDX_W-1:0];
               cur_e_in = rdata;
               phase_in = 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = res_off_ff;
               rsp_st_in    = res_st_ff;
            end
         end
         default: ;
      endcase
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_offset = rsp_off_ff;
   assign rsp_status        = rsp_st_ff;

   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled while an item is in work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result shown without a finished item");

   a_fail_zero_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_result_offset == '0))
      else $error("failed allocate carries a nonzero offset");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !mem.we)
      else $error("header memory written outside an item");

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with block splitting and free-block coalescing.
// ----------------------------------------------------------------------------
// One item is handled at a time; all block headers live in a single 4096-entry
// memory with one read and one write port, and that read port sets the rate.
// Init writes the first header. Allocate reads one header at a time along the
// list walk, then writes back the headers that the split changes; free walks
// the list the same way, then merges the block with a free successor and a
// free predecessor. The result sits in an output register, so the next item
// is taken while it waits. There is no clearing pass; the heap must be
// initialized before the first allocate or free.
module first_fit_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [16:0] req_size,
   input  logic [15:0] req_payload_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_offset,
   output logic [1:0]  rsp_status
);
   import ffha_pkg::*;

   logic [PAGES_W-1:0] heap_pages_ff, heap_pages_in;
   logic [PAGES_W-1:0] pages;
   mem_req_type        mem;
   entry_type          rdata;
   logic [ENTRY_W-1:0] rdata_raw;

   assign heap_pages_in = csr_we ? csr_wdata : heap_pages_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_pages_ff <= PAGES_W'(MAX_PAGES);
      end else begin
         heap_pages_ff <= heap_pages_in;
      end
   end

   // A page count of zero acts as one; counts above the maximum are capped.
   always_comb begin
      pages = heap_pages_ff;
      if (heap_pages_ff == '0) begin
         pages = PAGES_W'(1);
      end else if (heap_pages_ff > PAGES_W'(MAX_PAGES)) begin
         pages = PAGES_W'(MAX_PAGES);
      end
   end

   ffha_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .pages              (pages),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_size           (req_size),
      .req_payload_offset (req_payload_offset),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_offset  (rsp_result_offset),
      .rsp_status         (rsp_status),
      .mem                (mem),
      .rdata              (rdata)
   );

   ffha_ram #(
      .DATA_W (ENTRY_W),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock (clock),
      .we    (mem.we),
      .waddr (mem.waddr),
      .wdata (mem.wdata),
      .re    (mem.re),
      .raddr (mem.raddr),
      .rdata (rdata_raw)
   );

   assign rdata = entry_type'(rdata_raw);

endmodule

// ===== tb/sv/first_fit_heap_allocator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_checker
// Watches the request and response channels of the heap allocator. It keeps
// its own copy of the block list, computes the answer for each accepted
// item, and compares every response with the oldest pending answer.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_checker
   import ffha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [16:0] req_size,
   input  logic [15:0] req_payload_offset,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_result_offset,
   input  logic [1:0]  rsp_status,
   output int          error_count,
   output int          answers_pending
);

   localparam int NBLK = 1 << IDX_W;

   typedef struct packed {
      logic [15:0] offset;
      status_type  status;
   } answer_type;

   logic [4:0]        heap_pages_q;
   logic [LEN_W-1:0]  blk_len  [NBLK];
   logic [LINK_W-1:0] blk_next [NBLK];
   logic [LINK_W-1:0] blk_prev [NBLK];
   logic              blk_free [NBLK];
   logic [IDX_W-1:0]  tail_blk;
   answer_type        answer_queue[$];

   assign answers_pending = answer_queue.size();

   function automatic void absorb_successor(int b);
      int nx;
      int nn;
      nx = blk_next[b];
      if (nx >= NBLK || !blk_free[nx]) return;
      if (tail_blk == nx) tail_blk = IDX_W'(b);
      nn = blk_next[nx];
      if (nn < NBLK) blk_prev[nn] = LINK_W'(b);
      else nn = NBLK;
      blk_len[b]  = LEN_W'(blk_len[b] + blk_len[nx] + HDR_BYTES);
      blk_next[b] = LINK_W'(nn);
   endfunction

   function automatic void carve_block(int cur, int size);
      int len;
      int nb;
      int old;
      len = blk_len[cur];
      if (size < 16 || len < size + HDR_BYTES + 16) return;
      nb = cur + (size + HDR_BYTES) / 16;
      if (nb >= NBLK) return;
      old = blk_next[cur];
      if (old < NBLK) blk_prev[old] = LINK_W'(nb);
      else old = NBLK;
      blk_next[nb] = LINK_W'(old);
      blk_next[cur] = LINK_W'(nb);
      blk_prev[nb] = LINK_W'(cur);
      blk_len[nb] = LEN_W'(len - size - HDR_BYTES);
      blk_free[nb] = blk_free[cur];
      blk_len[cur] = LEN_W'(size);
      if (tail_blk == cur) tail_blk = IDX_W'(nb);
   endfunction

   function automatic answer_type heap_answer(cmd_type cmd, int size, int off);
      answer_type a;
      int pages;
      int cur;
      int nx;
      int target;
      int pv;
      bit found;
      a.offset = '0;
      a.status = ST_OK;
      case (cmd)
         CMD_INIT: begin
            pages = heap_pages_q;
            if (pages == 0) pages = 1;
            if (pages > MAX_PAGES) pages = MAX_PAGES;
            blk_len[0]  = LEN_W'(pages * 4096 - HDR_BYTES);
            blk_next[0] = LINK_W'(NBLK);
            blk_prev[0] = LINK_W'(NBLK);
            blk_free[0] = 1'b1;
            tail_blk    = '0;
         end
         CMD_ALLOC: begin
            if (size % 16 != 0) size = size - size % 16 + 16;
            if (size == 0) begin
               a.status = ST_ZERO;
            end else begin
               cur = 0;
               found = 0;
               a.status = ST_NOFIT;
               for (int s = 0; s < NBLK && !found; s++) begin
                  if (blk_free[cur] && blk_len[cur] >= size) begin
                     if (blk_len[cur] > size) carve_block(cur, size);
                     blk_free[cur] = 1'b0;
                     a.offset = 16'(cur * 16 + HDR_BYTES);
                     a.status = ST_OK;
                     found = 1;
                  end else begin
                     nx = blk_next[cur];
                     if (nx >= NBLK) break;
                     cur = nx;
                  end
               end
            end
         end
         CMD_FREE: begin
            if (off >= HDR_BYTES && (off - HDR_BYTES) % 16 == 0) begin
               target = (off - HDR_BYTES) / 16;
               cur = 0;
               found = (cur == target);
               for (int s = 0; s < NBLK && !found; s++) begin
                  nx = blk_next[cur];
                  if (nx >= NBLK) break;
                  cur = nx;
                  found = (cur == target);
               end
               if (found && !blk_free[cur]) begin
                  blk_free[cur] = 1'b1;
                  absorb_successor(cur);
                  pv = blk_prev[cur];
                  if (pv < NBLK && blk_free[pv]) absorb_successor(pv);
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      int errs;
      errs = 0;
      if (reset) begin
         heap_pages_q <= 5'd16;
         tail_blk = '0;
         error_count <= 0;
         answer_queue.delete();
      end else begin
         if (csr_we) heap_pages_q <= csr_wdata;
         if (req_valid && !req_stall)
            answer_queue.push_back(heap_answer(cmd_type'(req_cmd), req_size,
                                               req_payload_offset));
         if (rsp_valid && !rsp_stall) begin
            if (answer_queue.size() == 0) begin
               $error("response with no item outstanding");
               errs++;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_result_offset !== want.offset) begin
                  $error("result_offset: expected %0d, got %0d", want.offset,
                         rsp_result_offset);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errs++;
               end
            end
         end
         if (errs != 0) error_count <= error_count + errs;
      end
   end

endmodule

// ===== tb/sv/first_fit_heap_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives init, allocate, free and no-op items into the allocator under random
// idling and back-pressure, across several heap sizes, with a checker beside.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
   import ffha_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [4:0]  csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [16:0] req_size;
   logic [15:0] req_payload_offset;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_result_offset;
   logic [1:0]  rsp_status;
   int          error_count;
   int          answers_pending;

   logic        calm;
   logic        hold_off;
   int          quiet_cycles;
   logic [15:0] live_offsets[$];

   first_fit_heap_allocator uut (.*);

   first_fit_heap_allocator_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: random stalls, none while calm, a solid block on hold_off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || (!calm && $urandom_range(99) < 27);
      end
   end

   // Remember granted payloads so that frees mostly name real blocks.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_status == ST_OK
          && rsp_result_offset != 0)
         live_offsets.push_back(rsp_result_offset);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Valid stays high after an accepted item until the next item or an idle
   // cycle replaces it; the block stalls right after every accept.
   task automatic send_item(cmd_type cmd, logic [16:0] size, logic [15:0] off);
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_size <= size;
      req_payload_offset <= off;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_and_set(logic [4:0] pages);
      req_valid <= 1'b0;
      while (answers_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= pages;
      @(posedge clock);
      csr_we <= 1'b0;
      live_offsets.delete();
   endtask

   task automatic random_item();
      int pick;
      int k;
      pick = $urandom_range(99);
      if (pick < 48) begin
         case ($urandom_range(3))
            0: send_item(CMD_ALLOC, 17'($urandom_range(1, 64)), 16'($urandom));
            1: send_item(CMD_ALLOC, 17'($urandom_range(1, 600)), 16'($urandom));
            2: send_item(CMD_ALLOC, 17'($urandom_range(0, 4096)), 16'($urandom));
            default: send_item(CMD_ALLOC, 17'($urandom), 16'($urandom));
         endcase
      end else if (pick < 88 && live_offsets.size() != 0) begin
         k = $urandom_range(live_offsets.size() - 1);
         send_item(CMD_FREE, 17'($urandom), live_offsets[k]);
         live_offsets.delete(k);
      end else if (pick < 96) begin
         send_item(CMD_FREE, 17'($urandom), 16'($urandom));
      end else if (pick < 98) begin
         send_item(CMD_NOP, 17'($urandom), 16'($urandom));
      end else begin
         send_item(CMD_INIT, 17'($urandom), 16'($urandom));
         live_offsets.delete();
      end
   endtask

   initial begin
      logic [4:0] page_plan[5];
      page_plan = '{5'd1, 5'd31, 5'd0, 5'd4, 5'd16};
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_cmd = CMD_INIT;
      req_size = '0;
      req_payload_offset = '0;
      calm = 1'b0;
      hold_off = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of each field and the odd cases of the list.
      send_item(CMD_INIT, 17'h1FFFF, 16'hFFFF);
      send_item(CMD_ALLOC, 17'd0, 16'd0);
      send_item(CMD_ALLOC, 17'd1, 16'd0);
      send_item(CMD_ALLOC, 17'd16, 16'd0);
      send_item(CMD_ALLOC, 17'd17, 16'd0);
      send_item(CMD_ALLOC, 17'd65536, 16'd0);
      send_item(CMD_ALLOC, 17'h1FFFF, 16'd0);
      send_item(CMD_FREE, 17'd0, 16'd0);
      send_item(CMD_FREE, 17'd0, 16'd40);
      send_item(CMD_FREE, 17'd0, 16'hFFFF);
      send_item(CMD_FREE, 17'd0, 16'd32);
      send_item(CMD_FREE, 17'd0, 16'd32);
      send_item(CMD_FREE, 17'd0, 16'd112);
      send_item(CMD_FREE, 17'd0, 16'd80);
      send_item(CMD_NOP, 17'h1FFFF, 16'hFFFF);
      send_item(CMD_ALLOC, 17'd65440, 16'd0);
      send_item(CMD_ALLOC, 17'd16, 16'd0);
      send_item(CMD_FREE, 17'd0, 16'd32);
      send_item(CMD_ALLOC, 17'd65504, 16'd0);
      send_item(CMD_ALLOC, 17'd65505, 16'd0);

      for (int phase = 0; phase < 5; phase++) begin
         drain_and_set(page_plan[phase]);
         send_item(CMD_INIT, 17'($urandom), 16'($urandom));
         if (phase == 1) begin
            calm = 1'b1;
            fork
               begin
                  hold_off = 1'b1;
                  repeat (400) @(posedge clock);
                  hold_off = 1'b0;
               end
               repeat (30) random_item();
            join
            repeat (40) random_item();
            calm = 1'b0;
         end
         repeat (140) random_item();
      end

      req_valid <= 1'b0;
      while (answers_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
